// ===== hdl/mrorb_pkg.sv =====
// shared types, constants and helpers of the multi-reader overwrite ring buffer
package mrorb_pkg;

    localparam int DEPTH      = 16;
    localparam int READERS    = 4;
    localparam int DATA_WIDTH = 32;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int RIDX_W  = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CNT_W   = $clog2(READERS + 1);
    localparam int RID_W   = 2;
    localparam int MAX_W   = 4;
    localparam int DOUT_W  = 32;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    typedef enum logic [1:0] {
        OP_WRITE     = 2'd0,
        OP_READ      = 2'd1,
        OP_NEWEST    = 2'd2,
        OP_SUBSCRIBE = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_BURST
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [DATA_WIDTH-1:0] data;
        logic [RID_W-1:0]      rid;
        logic [MAX_W-1:0]      max_count;
        logic                  no_count;
    } cmd_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

endpackage

// ===== hdl/multi_reader_overwrite_ring_buffer.sv =====
// top level of the multi-reader overwrite ring buffer
//
// commands arrive on the s_axis channel: tuser carries the command code (write, read for
// a reader, read newest, subscribe), tdata the data word, reader id and entry limit.
// every command answers with one or more result transactions on m_axis; tlast marks the
// final one, tuser flags that tdata carries a stored entry.
// a front stage registers and decodes each command into a two-deep queue, and the engine
// behind it owns the 16-word store, the write position and one read position per reader.
// an input transaction passes the front register, a queue slot and the result register.
// writes, subscribes, read-newest and empty reads give one result each; a read that
// returns n entries gives one result per entry and keeps the engine until it is done.
// when the receiver stalls the result register holds; the queue and front stage then fill
// and s_axis_tready drops until results are taken again.
// reset clears the write position, reader count and data-present flag; no clearing pass
// is run, so commands are taken from the first cycle after reset.
module multi_reader_overwrite_ring_buffer (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_in [31:0], reader_id [33:32], max_count [37:34], zero fill [39:38]
    input  logic [mrorb_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd [1:0]
    input  logic [1:0]                      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // data_out [31:0], ok [32], assigned_id [34:33], zero fill [39:35]
    output logic [mrorb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // valid_res [0]
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic            push_valid;
    logic            push_ready;
    mrorb_pkg::cmd_t push_cmd;
    logic            head_valid;
    mrorb_pkg::cmd_t head_cmd;
    logic            pop;

    mrorb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    mrorb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    mrorb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hdl/mrorb_front.sv =====
// front end: takes input transactions, decodes the command and holds it for the queue
module mrorb_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [mrorb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [1:0]                          s_axis_tuser,
    output logic                                push_valid,
    input  logic                                push_ready,
    output mrorb_pkg::cmd_t                     push_cmd
);

    logic            hold_valid_reg;
    logic            hold_valid_next;
    mrorb_pkg::cmd_t hold_cmd_reg;
    mrorb_pkg::cmd_t decoded;
    logic            accept;

    assign s_axis_tready = !hold_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        decoded.op        = mrorb_pkg::op_t'(s_axis_tuser);
        decoded.data      = s_axis_tdata[mrorb_pkg::DATA_WIDTH-1:0];
        decoded.rid       = s_axis_tdata[33:32];
        decoded.max_count = s_axis_tdata[37:34];
        decoded.no_count  = (s_axis_tdata[37:34] == '0);
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_cmd_reg <= decoded;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

endmodule

// ===== hdl/mrorb_queue.sv =====
// short command queue between the front end and the execution engine
module mrorb_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  mrorb_pkg::cmd_t push_cmd,
    output logic            head_valid,
    output mrorb_pkg::cmd_t head_cmd,
    input  logic            pop
);

    mrorb_pkg::cmd_t                 slots_reg [mrorb_pkg::QDEPTH];
    logic [mrorb_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mrorb_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [mrorb_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mrorb_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [mrorb_pkg::QCNT_W-1:0]    count_reg;
    logic [mrorb_pkg::QCNT_W-1:0]    count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != mrorb_pkg::QCNT_W'(mrorb_pkg::QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrorb_pkg::QPTR_W'(mrorb_pkg::QDEPTH - 1))
                          ? '0 : wr_ptr_reg + mrorb_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrorb_pkg::QPTR_W'(mrorb_pkg::QDEPTH - 1))
                          ? '0 : rd_ptr_reg + mrorb_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + mrorb_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - mrorb_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hdl/mrorb_back.sv =====
// execution engine: ring store, reader positions and the result register
module mrorb_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  mrorb_pkg::cmd_t                 head_cmd,
    output logic                            pop,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mrorb_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [0:0]                      m_axis_tuser,
    output logic                            m_axis_tlast
);

    logic [mrorb_pkg::DATA_WIDTH-1:0] entries [mrorb_pkg::DEPTH];

    mrorb_pkg::state_t                state_reg;
    mrorb_pkg::state_t                state_next;
    logic [mrorb_pkg::PTR_W-1:0]      wp_reg;
    logic [mrorb_pkg::PTR_W-1:0]      wp_next;
    logic [mrorb_pkg::PTR_W-1:0]      rp_reg [mrorb_pkg::READERS];
    logic [mrorb_pkg::PTR_W-1:0]      rp_next [mrorb_pkg::READERS];
    logic [mrorb_pkg::CNT_W-1:0]      cnt_reg;
    logic [mrorb_pkg::CNT_W-1:0]      cnt_next;
    logic                             dp_reg;
    logic                             dp_next;
    logic [mrorb_pkg::MAX_W-1:0]      rem_reg;
    logic [mrorb_pkg::MAX_W-1:0]      rem_next;
    logic [mrorb_pkg::RIDX_W-1:0]     rid_reg;
    logic [mrorb_pkg::RIDX_W-1:0]     rid_next;

    logic                             out_valid_reg;
    logic [mrorb_pkg::DOUT_W-1:0]     out_data_reg;
    logic                             out_vres_reg;
    logic                             out_ok_reg;
    logic [mrorb_pkg::RID_W-1:0]      out_id_reg;
    logic                             out_last_reg;

    logic                             out_free;
    logic                             load;
    logic [mrorb_pkg::DOUT_W-1:0]     e_data;
    logic                             e_vres;
    logic                             e_ok;
    logic [mrorb_pkg::RID_W-1:0]      e_id;
    logic                             e_last;
    logic                             go_burst;
    logic                             burst_done;
    logic                             mem_we;
    logic [mrorb_pkg::PTR_W-1:0]      mem_addr;
    logic [mrorb_pkg::RIDX_W-1:0]     cur_rid;
    logic [mrorb_pkg::PTR_W-1:0]      rd_pos;
    logic [mrorb_pkg::PTR_W-1:0]      new_wp;
    logic                             known;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign cur_rid  = (state_reg == mrorb_pkg::ST_IDLE)
                      ? mrorb_pkg::RIDX_W'(head_cmd.rid) : rid_reg;
    assign rd_pos   = mrorb_pkg::next_slot(rp_reg[cur_rid]);
    assign new_wp   = mrorb_pkg::next_slot(wp_reg);
    assign known    = (32'(head_cmd.rid) < 32'(cnt_reg));

    // datapath and handshake decisions
    always_comb
    begin
        pop        = 1'b0;
        load       = 1'b0;
        go_burst   = 1'b0;
        burst_done = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = new_wp;
        e_data     = '0;
        e_vres     = 1'b0;
        e_ok       = 1'b0;
        e_id       = '0;
        e_last     = 1'b1;
        wp_next    = wp_reg;
        cnt_next   = cnt_reg;
        dp_next    = dp_reg;
        rem_next   = rem_reg;
        rid_next   = rid_reg;
        for (int i = 0; i < mrorb_pkg::READERS; i++)
        begin
            rp_next[i] = rp_reg[i];
        end
        case (state_reg)
            mrorb_pkg::ST_IDLE:
            begin
                if (head_valid && out_free)
                begin
                    load = 1'b1;
                    pop  = 1'b1;
                    case (head_cmd.op)
                        mrorb_pkg::OP_WRITE:
                        begin
                            // a reader parked on the new slot loses its oldest entry
                            for (int i = 0; i < mrorb_pkg::READERS; i++)
                            begin
                                if (i < int'(cnt_reg) && rp_reg[i] == new_wp)
                                begin
                                    rp_next[i] = mrorb_pkg::next_slot(rp_reg[i]);
                                end
                            end
                            wp_next = new_wp;
                            mem_we  = 1'b1;
                            dp_next = 1'b1;
                            e_ok    = 1'b1;
                        end
                        mrorb_pkg::OP_SUBSCRIBE:
                        begin
                            if (32'(cnt_reg) < 32'(mrorb_pkg::READERS))
                            begin
                                rp_next[mrorb_pkg::RIDX_W'(cnt_reg)] = wp_reg;
                                cnt_next = cnt_reg + mrorb_pkg::CNT_W'(1);
                                e_ok     = 1'b1;
                                e_id     = mrorb_pkg::RID_W'(cnt_reg);
                            end
                        end
                        mrorb_pkg::OP_NEWEST:
                        begin
                            if (dp_reg)
                            begin
                                e_data = mrorb_pkg::DOUT_W'(entries[wp_reg]);
                                e_vres = 1'b1;
                                e_ok   = 1'b1;
                            end
                        end
                        mrorb_pkg::OP_READ:
                        begin
                            if (known)
                            begin
                                e_ok = 1'b1;
                                if (!head_cmd.no_count && rp_reg[cur_rid] != wp_reg)
                                begin
                                    e_data           = mrorb_pkg::DOUT_W'(entries[rd_pos]);
                                    e_vres           = 1'b1;
                                    rp_next[cur_rid] = rd_pos;
                                    e_last = (head_cmd.max_count == mrorb_pkg::MAX_W'(1))
                                             || (rd_pos == wp_reg);
                                    if (!e_last)
                                    begin
                                        pop      = 1'b0;
                                        go_burst = 1'b1;
                                        rem_next = head_cmd.max_count - mrorb_pkg::MAX_W'(1);
                                        rid_next = cur_rid;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            e_ok = 1'b0;
                        end
                    endcase
                end
            end
            mrorb_pkg::ST_BURST:
            begin
                if (out_free)
                begin
                    load             = 1'b1;
                    e_data           = mrorb_pkg::DOUT_W'(entries[rd_pos]);
                    e_vres           = 1'b1;
                    e_ok             = 1'b1;
                    rp_next[cur_rid] = rd_pos;
                    rem_next         = rem_reg - mrorb_pkg::MAX_W'(1);
                    e_last = (rem_reg == mrorb_pkg::MAX_W'(1)) || (rd_pos == wp_reg);
                    if (e_last)
                    begin
                        pop        = 1'b1;
                        burst_done = 1'b1;
                    end
                end
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mrorb_pkg::ST_IDLE:
            begin
                if (go_burst)
                begin
                    state_next = mrorb_pkg::ST_BURST;
                end
            end
            mrorb_pkg::ST_BURST:
            begin
                if (burst_done)
                begin
                    state_next = mrorb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrorb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrorb_pkg::ST_IDLE;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            dp_reg        <= 1'b0;
            rem_reg       <= '0;
            rid_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
            dp_reg    <= dp_next;
            rem_reg   <= rem_next;
            rid_reg   <= rid_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // positions stay undefined until the reader subscribes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mrorb_pkg::READERS; i++)
        begin
            rp_reg[i] <= rp_next[i];
        end
        if (load)
        begin
            out_data_reg <= e_data;
            out_vres_reg <= e_vres;
            out_ok_reg   <= e_ok;
            out_id_reg   <= e_id;
            out_last_reg <= e_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entries[mem_addr] <= head_cmd.data;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_id_reg, out_ok_reg, out_data_reg};
    assign m_axis_tuser  = out_vres_reg;
    assign m_axis_tlast  = out_last_reg;

    a_burst_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrorb_pkg::ST_BURST) |-> (rem_reg != '0))
        else $error("burst running with no entries left");

    a_pop_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (load && head_valid))
        else $error("command retired without a result transaction");

    a_write_sets_present: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_cmd.op == mrorb_pkg::OP_WRITE) |=> dp_reg)
        else $error("data-present flag not set after a write");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg >= $past(cnt_reg)
                  && 32'(cnt_reg) <= 32'(mrorb_pkg::READERS)))
        else $error("reader count fell or overran the reader slots");

    a_burst_last_retires: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrorb_pkg::ST_BURST && load && e_last) |=>
        (state_reg == mrorb_pkg::ST_IDLE))
        else $error("burst did not end on its last transaction");

endmodule
